// ===== sv/sps_pkg.sv =====
// shared types and constants of the 3x3 sharpening filter
package sps_pkg;

	localparam int PIX_BITS       = 8;
	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
	localparam int DIM_BITS       = 11;
	localparam int SUM_BITS       = PIX_BITS + 2;
	localparam int TOTAL_BITS     = PIX_BITS + 4;
	localparam int OUT_BITS       = 13;
	localparam int CFG_INDEX_BITS = 1;
	localparam int N_RESULTS      = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// one window column, top row first, with its two row-set sums
	typedef struct packed {
		logic [PIX_BITS-1:0] p0;
		logic [PIX_BITS-1:0] p1;
		logic [PIX_BITS-1:0] p2;
		logic [SUM_BITS-1:0] sum_a;
		logic [SUM_BITS-1:0] sum_b;
	} sps_col_t;

	typedef struct packed {
		logic en;
		logic load_new;
	} sps_cell_ctrl_t;

endpackage

// ===== sv/sps_pixel_if.sv =====
// input pixel channel
interface sps_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [sps_pkg::PIX_BITS-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== sv/sps_result_if.sv =====
// filtered result channel
interface sps_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [sps_pkg::OUT_BITS-1:0] filtered_value;
	logic                                frame_last;

	modport source (output valid, output filtered_value, output frame_last, input ready);
	modport sink (input valid, input filtered_value, input frame_last, output ready);
endinterface

// ===== sv/sps_line_store.sv =====
// one image line of pixels, one write and one registered read port
module sps_line_store (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [sps_pkg::COL_BITS-1:0] wr_addr,
	input  logic [sps_pkg::PIX_BITS-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [sps_pkg::COL_BITS-1:0] rd_addr,
	output logic [sps_pkg::PIX_BITS-1:0] rd_data
);

	logic [sps_pkg::PIX_BITS-1:0] mem_q [sps_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/sps_cell.sv =====
// one window column cell: loads a fresh column or takes its neighbour's
module sps_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sps_pkg::sps_cell_ctrl_t             ctrl,
	input  logic [2:0][sps_pkg::PIX_BITS-1:0]   new_pix,
	input  sps_pkg::sps_col_t                   nbr,
	output sps_pkg::sps_col_t                   col_q
);

	sps_pkg::sps_col_t nxt;

	always_comb begin
		nxt = nbr;
		if (ctrl.load_new) begin
			nxt.p0    = new_pix[0];
			nxt.p1    = new_pix[1];
			nxt.p2    = new_pix[2];
			nxt.sum_a = {2'b00, new_pix[0]} + {2'b00, new_pix[1]} + {2'b00, new_pix[2]};
			nxt.sum_b = {2'b00, new_pix[1]} + {1'b0, new_pix[2], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.en) begin
			col_q <= nxt;
		end
	end

endmodule

// ===== sv/sharpen_3x3_edge_replicate.sv =====
// top level of the streaming 3x3 sharpening filter with edge replication
//
// Pixels enter in raster order on the pix channel, one word per accepted
// handshake; results leave on the res channel, signed and not clamped, with
// frame_last set on the final result of an image. Image width and height
// are written through the cfg port (index 0 width, index 1 height); a write
// also restarts the frame. Zero acts as one, values above 1024 as 1024.
// A result leaves as soon as its window is complete, so it may come out
// only after the pixel below-right of it has been taken.
// Throughput: one pixel per cycle while each pixel releases at most one
// result and the receiver is ready. The single output register sends
// one result per cycle while the receiver is ready; a pixel that
// releases more (row end, last row) stalls the input until its last
// result is sent. A result passes the stage 1, cell and output registers.
// When the receiver stalls, the result waits in the output register and
// the cell chain holds the pixel whose results are still due; pixels that
// release nothing pass until then. One more pixel waits at the line store
// read, then the input stalls in turn.
// Reset: both sizes go to 1024, the frame position to the first pixel, and
// no result is pending. The line stores need no clearing.
module sharpen_3x3_edge_replicate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sps_pkg::DIM_BITS-1:0]        cfg_data,
	sps_pixel_if.sink                           pix,
	sps_result_if.source                        res
);

	logic [sps_pkg::DIM_BITS-1:0] width_q;
	logic [sps_pkg::DIM_BITS-1:0] height_q;
	logic [sps_pkg::DIM_BITS-1:0] eff_w;
	logic [sps_pkg::DIM_BITS-1:0] eff_h;
	logic [sps_pkg::COL_BITS-1:0] col_q;
	logic [sps_pkg::ROW_BITS-1:0] row_q;
	logic                         last_col;
	logic                         last_row;
	logic                         accept;

	logic                         v_s1;
	logic [sps_pkg::PIX_BITS-1:0] p_s1;
	logic [sps_pkg::COL_BITS-1:0] x_s1;
	logic                         x0_s1;
	logic                         y0_s1;
	logic                         lc_s1;
	logic                         lr_s1;
	logic                         fwd_s1;
	logic [sps_pkg::PIX_BITS-1:0] fwd_data_s1;
	logic [sps_pkg::PIX_BITS-1:0] upper_rd;
	logic [sps_pkg::PIX_BITS-1:0] lower_rd;
	logic [sps_pkg::PIX_BITS-1:0] up_s1;
	logic [sps_pkg::PIX_BITS-1:0] mid_s1;
	logic [sps_pkg::N_RESULTS-1:0] mask_new;

	logic [sps_pkg::N_RESULTS-1:0] mask_s2;
	logic [sps_pkg::N_RESULTS-1:0] pick;
	logic [1:0]                    pick_idx;
	logic                          emit;
	logic                          adv;

	sps_pkg::sps_cell_ctrl_t       ctrl_edge;
	sps_pkg::sps_cell_ctrl_t       ctrl_tail;
	logic [2:0][sps_pkg::PIX_BITS-1:0] new_pix;
	sps_pkg::sps_col_t             win0;
	sps_pkg::sps_col_t             win1;
	sps_pkg::sps_col_t             win2;

	logic                            row_b;
	logic                            col_b;
	logic [sps_pkg::SUM_BITS-1:0]    s0;
	logic [sps_pkg::SUM_BITS-1:0]    s1;
	logic [sps_pkg::SUM_BITS-1:0]    s2;
	logic [sps_pkg::TOTAL_BITS-1:0]  total;
	logic [sps_pkg::PIX_BITS-1:0]    centre;
	logic [sps_pkg::TOTAL_BITS-1:0]  ten_c;
	logic signed [sps_pkg::OUT_BITS-1:0] value;

	logic                            res_v_q;
	logic signed [sps_pkg::OUT_BITS-1:0] res_val_q;
	logic                            res_last_q;

	// configuration and frame position
	always_comb begin
		if (width_q == '0) begin
			eff_w = sps_pkg::DIM_BITS'(1);
		end else if (width_q > sps_pkg::DIM_BITS'(sps_pkg::MAX_WIDTH)) begin
			eff_w = sps_pkg::DIM_BITS'(sps_pkg::MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = sps_pkg::DIM_BITS'(1);
		end else if (height_q > sps_pkg::DIM_BITS'(sps_pkg::MAX_HEIGHT)) begin
			eff_h = sps_pkg::DIM_BITS'(sps_pkg::MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	assign last_col = (sps_pkg::DIM_BITS'(col_q) + sps_pkg::DIM_BITS'(1)) == eff_w;
	assign last_row = (sps_pkg::DIM_BITS'(row_q) + sps_pkg::DIM_BITS'(1)) == eff_h;
	assign pix.ready = !v_s1 || adv;
	assign accept = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sps_pkg::DIM_BITS'(sps_pkg::MAX_WIDTH);
			height_q <= sps_pkg::DIM_BITS'(sps_pkg::MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sps_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data;
				sps_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + sps_pkg::ROW_BITS'(1);
			end else begin
				col_q <= col_q + sps_pkg::COL_BITS'(1);
			end
		end
	end

	// line stores
	sps_line_store u_upper (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (x_s1),
		.wr_data (mid_s1),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (upper_rd)
	);

	sps_line_store u_lower (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (pix.pixel_in),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lower_rd)
	);

	// stage 1: line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1        <= pix.pixel_in;
			x_s1        <= col_q;
			x0_s1       <= (col_q == '0);
			y0_s1       <= (row_q == '0);
			lc_s1       <= last_col;
			lr_s1       <= last_row;
			// upper line written in this same cycle at the address being read
			fwd_s1      <= adv && (x_s1 == col_q);
			fwd_data_s1 <= mid_s1;
		end
	end

	always_comb begin
		if (y0_s1) begin
			up_s1  = p_s1;
			mid_s1 = p_s1;
		end else begin
			up_s1  = fwd_s1 ? fwd_data_s1 : upper_rd;
			mid_s1 = lower_rd;
		end
		mask_new[0] = !y0_s1 && !x0_s1;
		mask_new[1] = !y0_s1 && lc_s1;
		mask_new[2] = lr_s1 && !x0_s1;
		mask_new[3] = lr_s1 && lc_s1;
	end

	// window cell chain
	assign new_pix            = {p_s1, mid_s1, up_s1};
	assign ctrl_edge.en       = adv;
	assign ctrl_edge.load_new = x0_s1;
	assign ctrl_tail.en       = adv;
	assign ctrl_tail.load_new = 1'b1;

	sps_cell u_cell0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_edge),
		.new_pix (new_pix),
		.nbr     (win1),
		.col_q   (win0)
	);

	sps_cell u_cell1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_edge),
		.new_pix (new_pix),
		.nbr     (win2),
		.col_q   (win1)
	);

	sps_cell u_cell2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_tail),
		.new_pix (new_pix),
		.nbr     (win2),
		.col_q   (win2)
	);

	// stage 2: result sequencer
	always_comb begin
		if (mask_s2[0]) begin
			pick_idx = 2'd0;
		end else if (mask_s2[1]) begin
			pick_idx = 2'd1;
		end else if (mask_s2[2]) begin
			pick_idx = 2'd2;
		end else begin
			pick_idx = 2'd3;
		end
		pick = sps_pkg::N_RESULTS'(1) << pick_idx;
		emit = (mask_s2 != '0) && (!res_v_q || res.ready);
		adv  = v_s1 && ((mask_s2 & ~(emit ? pick : '0)) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (adv) begin
			mask_s2 <= mask_new;
		end else if (emit) begin
			mask_s2 <= mask_s2 & ~pick;
		end
	end

	always_comb begin
		row_b = pick_idx[1];
		col_b = pick_idx[0];
		s0 = row_b ? win0.sum_b : win0.sum_a;
		s1 = row_b ? win1.sum_b : win1.sum_a;
		s2 = row_b ? win2.sum_b : win2.sum_a;
		if (col_b) begin
			total = {2'b00, s1} + {1'b0, s2, 1'b0};
			centre = row_b ? win2.p2 : win2.p1;
		end else begin
			total = {2'b00, s0} + {2'b00, s1} + {2'b00, s2};
			centre = row_b ? win1.p2 : win1.p1;
		end
		ten_c = {1'b0, centre, 3'b000} + {3'b000, centre, 1'b0};
		value = $signed({1'b0, ten_c}) - $signed({1'b0, total});
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_val_q  <= value;
			res_last_q <= (pick_idx == 2'd3);
		end
	end

	assign res.valid          = res_v_q;
	assign res.filtered_value = res_val_q;
	assign res.frame_last     = res_last_q;

endmodule
